### rtl/core/mmcs_pkg.sv
// Shared constants for the min/max contrast stretch block.
// Used by the channel interfaces, the divider and the top level.
package mmcs_pkg;

  // Defaults for the top-level parameters
  localparam int DEF_MAX_SIDE    = 256;
  localparam int DEF_SAMPLE_BITS = 32;

  // Fixed field widths
  localparam int SAMPLE_W  = 32;
  localparam int COORD_W   = 8;
  localparam int CFG_W     = 9;
  localparam int SIDE_W    = 9;
  localparam int TOT_W     = 2 * SIDE_W;
  localparam int PIX_W     = 16;
  localparam int Q_BITS    = 16;
  localparam int REG_IDX_W = 2;

  localparam logic [PIX_W-1:0] Q88_FULL = 16'd65280;

  // Configuration register indexes
  localparam logic [REG_IDX_W-1:0] REG_WIDTH  = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_HEIGHT = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_FLIP   = 2'd2;

  // Read orders
  localparam logic [1:0] FLIP_ROT    = 2'd0;
  localparam logic [1:0] FLIP_ORIG   = 2'd1;
  localparam logic [1:0] FLIP_MIRROR = 2'd2;

  // Reset values of the size registers
  localparam logic [CFG_W-1:0] SIDE_RESET = 9'd256;

endpackage

### rtl/core/mmcs_if.sv
// Valid/ready channel interfaces: request items, result items, register writes.
// Depends on mmcs_pkg for field widths.
interface mmcs_req_if;
  logic                                  valid;
  logic                                  ready;
  logic                                  is_read;
  logic                                  first_of_frame;
  logic signed [mmcs_pkg::SAMPLE_W-1:0]  sample;
  logic        [mmcs_pkg::COORD_W-1:0]   read_col;
  logic        [mmcs_pkg::COORD_W-1:0]   read_row;

  modport source (output valid, is_read, first_of_frame, sample, read_col, read_row,
                  input ready);
  modport sink (input valid, is_read, first_of_frame, sample, read_col, read_row,
                output ready);
endinterface

interface mmcs_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [mmcs_pkg::PIX_W-1:0]    scaled_pixel;
  logic                          frame_incomplete;

  modport source (output valid, scaled_pixel, frame_incomplete, input ready);
  modport sink (input valid, scaled_pixel, frame_incomplete, output ready);
endinterface

interface mmcs_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [mmcs_pkg::REG_IDX_W-1:0]    reg_index;
  logic [mmcs_pkg::CFG_W-1:0]        wdata;

  modport source (output valid, reg_index, wdata, input ready);
  modport sink (input valid, reg_index, wdata, output ready);
endinterface

### rtl/core/minmax_contrast_stretch_frame.sv
// Min/max contrast stretch over one stored frame; uses mmcs_pkg, mmcs_if, mmcs_div.
// Write item: taken every cycle while no read is busy; stored and tracked in its accept cycle.
// Read item: states ADDR, DATA, then START and DIV when the 16-step divider runs, then DONE;
//   no new item is taken until the result is loaded, and a stalled result holds it in DONE.
// Reset: width and height 256, flip mode 0, pointer cleared, min and max set to zero;
//   the frame store is not cleared and has no clearing pass.
module minmax_contrast_stretch_frame #(
  parameter int MAX_SIDE    = mmcs_pkg::DEF_MAX_SIDE,
  parameter int SAMPLE_BITS = mmcs_pkg::DEF_SAMPLE_BITS
) (
  input  logic       clk,
  input  logic       rst,
  mmcs_req_if.sink   req,
  mmcs_rsp_if.source rsp,
  mmcs_cfg_if.sink   cfg
);
  localparam int DEPTH    = MAX_SIDE * MAX_SIDE;
  localparam int AW       = $clog2(DEPTH);
  localparam int EFF_SIDE = (MAX_SIDE < 511) ? MAX_SIDE : 511;
  localparam int PTR_W    = $clog2(EFF_SIDE * EFF_SIDE + 1);
  localparam int SW       = mmcs_pkg::SIDE_W;
  localparam int TW       = mmcs_pkg::TOT_W;
  localparam logic [SAMPLE_BITS-1:0] KEY_FLIP = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_ADDR  = 3'd1;
  localparam logic [2:0] ST_DATA  = 3'd2;
  localparam logic [2:0] ST_START = 3'd3;
  localparam logic [2:0] ST_DIV   = 3'd4;
  localparam logic [2:0] ST_DONE  = 3'd5;

  logic [2:0]                       state;
  logic [mmcs_pkg::CFG_W-1:0]       width_reg;
  logic [mmcs_pkg::CFG_W-1:0]       height_reg;
  logic [1:0]                       flip_reg;
  logic [PTR_W-1:0]                 wp;
  logic [SAMPLE_BITS-1:0]           min_key;
  logic [SAMPLE_BITS-1:0]           max_key;

  logic [SW-1:0]                    w_eff;
  logic [SW-1:0]                    h_eff;
  logic [TW-1:0]                    total;

  logic                             req_fire;
  logic                             wr_fire;
  logic                             rd_fire;
  logic [SAMPLE_BITS-1:0]           sample_key;
  logic [PTR_W-1:0]                 ptr_eff;
  logic                             store_ok;

  logic [SW-1:0]                    col_ext;
  logic [SW-1:0]                    row_ext;
  logic [SW-1:0]                    sr_next;
  logic [SW-1:0]                    sc_next;
  logic [SW-1:0]                    sr;
  logic [SW-1:0]                    sc;
  logic                             in_range;
  logic                             incomplete;
  logic [AW-1:0]                    rd_addr;

  logic [SAMPLE_BITS-1:0]           mem [DEPTH];
  logic [SAMPLE_BITS-1:0]           mem_q;

  logic [SAMPLE_BITS-1:0]           d_reg;
  logic [SAMPLE_BITS-1:0]           den_reg;
  logic [mmcs_pkg::PIX_W-1:0]       res;
  logic                             div_start;
  logic                             div_done;
  logic [mmcs_pkg::Q_BITS-1:0]      quot;
  logic                             rsp_free;

  // Clamp frame size to 1..MAX_SIDE
  always_comb begin
    if (width_reg == '0) begin
      w_eff = SW'(1);
    end else if (32'(width_reg) > MAX_SIDE) begin
      w_eff = SW'(MAX_SIDE);
    end else begin
      w_eff = width_reg;
    end
    if (height_reg == '0) begin
      h_eff = SW'(1);
    end else if (32'(height_reg) > MAX_SIDE) begin
      h_eff = SW'(MAX_SIDE);
    end else begin
      h_eff = height_reg;
    end
  end

  assign total = TW'(w_eff) * TW'(h_eff);

  // Configuration writes
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      width_reg  <= mmcs_pkg::SIDE_RESET;
      height_reg <= mmcs_pkg::SIDE_RESET;
      flip_reg   <= mmcs_pkg::FLIP_ROT;
    end else if (cfg.valid) begin
      case (cfg.reg_index)
        mmcs_pkg::REG_WIDTH:  width_reg  <= cfg.wdata;
        mmcs_pkg::REG_HEIGHT: height_reg <= cfg.wdata;
        mmcs_pkg::REG_FLIP:   flip_reg   <= cfg.wdata[1:0];
        default: ;
      endcase
    end
  end

  // Request handshake: one read in flight, writes finish at accept
  assign req.ready = (state == ST_IDLE);
  assign req_fire  = req.valid && req.ready;
  assign wr_fire   = req_fire && !req.is_read;
  assign rd_fire   = req_fire && req.is_read;

  // Samples kept as offset-binary keys so unsigned compare gives signed order
  assign sample_key = SAMPLE_BITS'($unsigned(req.sample)) ^ KEY_FLIP;
  assign ptr_eff    = req.first_of_frame ? '0 : wp;
  assign store_ok   = TW'(ptr_eff) < total;

  // Track write pointer and running min/max
  always_ff @(posedge clk) begin
    if (rst) begin
      wp      <= '0;
      min_key <= KEY_FLIP;
      max_key <= KEY_FLIP;
    end else if (wr_fire && store_ok) begin
      wp <= ptr_eff + 1'b1;
      if (ptr_eff == '0) begin
        min_key <= sample_key;
        max_key <= sample_key;
      end else begin
        if (sample_key < min_key) min_key <= sample_key;
        if (sample_key > max_key) max_key <= sample_key;
      end
    end
  end

  // Map the output coordinate to a stored raster position
  assign col_ext = SW'(req.read_col);
  assign row_ext = SW'(req.read_row);

  always_comb begin
    case (flip_reg)
      mmcs_pkg::FLIP_ORIG: begin
        sr_next = row_ext;
        sc_next = col_ext;
      end
      mmcs_pkg::FLIP_MIRROR: begin
        sr_next = h_eff - 1'b1 - row_ext;
        sc_next = col_ext;
      end
      default: begin
        sr_next = h_eff - 1'b1 - row_ext;
        sc_next = w_eff - 1'b1 - col_ext;
      end
    endcase
  end

  // Latch the read item
  always_ff @(posedge clk) begin
    if (rd_fire) begin
      sr         <= sr_next;
      sc         <= sc_next;
      in_range   <= (col_ext < w_eff) && (row_ext < h_eff);
      incomplete <= TW'(wp) < total;
    end
  end

  assign rd_addr = AW'(TW'(sr) * TW'(w_eff) + TW'(sc));

  // Frame store: write at accept, registered read in the address state
  always_ff @(posedge clk) begin
    if (wr_fire && store_ok) begin
      mem[AW'(ptr_eff)] <= sample_key;
    end
    if (state == ST_ADDR) begin
      mem_q <= mem[rd_addr];
    end
  end

  // Classify the pixel and set up the division
  always_ff @(posedge clk) begin
    if (state == ST_DATA) begin
      d_reg   <= mem_q - min_key;
      den_reg <= max_key - min_key;
      if (!in_range || max_key <= min_key || mem_q <= min_key) begin
        res <= '0;
      end else if (mem_q >= max_key) begin
        res <= mmcs_pkg::Q88_FULL;
      end else begin
        res <= '0;
      end
    end else if (state == ST_DIV && div_done) begin
      res <= quot;
    end
  end

  assign div_start = (state == ST_START);

  mmcs_div #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .d        (d_reg),
    .den      (den_reg),
    .done     (div_done),
    .quotient (quot)
  );

  assign rsp_free = !rsp.valid || rsp.ready;

  // Read sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      case (state)
        ST_IDLE:  if (rd_fire) state <= ST_ADDR;
        ST_ADDR:  state <= ST_DATA;
        ST_DATA: begin
          if (in_range && max_key > min_key && mem_q > min_key && mem_q < max_key) begin
            state <= ST_START;
          end else begin
            state <= ST_DONE;
          end
        end
        ST_START: state <= ST_DIV;
        ST_DIV:   if (div_done) state <= ST_DONE;
        ST_DONE:  if (rsp_free) state <= ST_IDLE;
        default:  state <= ST_IDLE;
      endcase
    end
  end

  // Output register: hold the item until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (state == ST_DONE && rsp_free) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && rsp_free) begin
      rsp.scaled_pixel     <= res;
      rsp.frame_incomplete <= incomplete;
    end
  end

  a_ready_idle_only: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> !req.ready) else $error("request taken while busy");
  a_min_le_max: assert property (@(posedge clk) disable iff (rst)
    min_key <= max_key) else $error("running min above running max");
  a_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == ST_DIV)) else $error("divider finished outside divide state");
  a_load_when_free: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE && !rsp_free) |=> (state == ST_DONE))
    else $error("result dropped while output full");

endmodule

### rtl/core/mmcs_div.sv
// Restoring divider: quotient = floor(65280 * d / den) for d < den, one bit a cycle.
// Depends on mmcs_pkg for the quotient width.
module mmcs_div #(
  parameter int SAMPLE_BITS = mmcs_pkg::DEF_SAMPLE_BITS
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [SAMPLE_BITS-1:0]       d,
  input  logic [SAMPLE_BITS-1:0]       den,
  output logic                         done,
  output logic [mmcs_pkg::Q_BITS-1:0]  quotient
);
  localparam int QB    = mmcs_pkg::Q_BITS;
  localparam int NW    = SAMPLE_BITS + QB;
  localparam int CNT_W = $clog2(QB);

  logic [NW-1:0]          num;
  logic [SAMPLE_BITS-1:0] rem;
  logic [SAMPLE_BITS-1:0] den_r;
  logic [QB-1:0]          nlow;
  logic [CNT_W-1:0]       cnt;
  logic                   busy;
  logic [SAMPLE_BITS:0]   trial;
  logic [SAMPLE_BITS:0]   diff;
  logic                   ge;

  // 65280 * d as (d << 16) - (d << 8)
  assign num = {d, {QB{1'b0}}} - {{(QB/2){1'b0}}, d, {(QB/2){1'b0}}};

  // One restoring step
  assign trial = {rem, nlow[QB-1]};
  assign diff  = trial - {1'b0, den_r};
  assign ge    = trial >= {1'b0, den_r};

  // Sequence the steps
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + 1'b1;
      if (cnt == CNT_W'(QB - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end else begin
        done <= 1'b0;
      end
    end else begin
      done <= 1'b0;
    end
  end

  // Remainder and quotient datapath
  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= num[NW-1:QB];
      nlow  <= num[QB-1:0];
      den_r <= den;
    end else if (busy) begin
      rem      <= ge ? diff[SAMPLE_BITS-1:0] : trial[SAMPLE_BITS-1:0];
      nlow     <= {nlow[QB-2:0], 1'b0};
      quotient <= {quotient[QB-2:0], ge};
    end
  end

  a_rem_below_den: assert property (@(posedge clk) disable iff (rst)
    busy |-> rem < den_r) else $error("divider remainder not below divisor");
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy)) else $error("divider done without a run");
  a_start_runs: assert property (@(posedge clk) disable iff (rst)
    start |=> busy) else $error("divider did not start");
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("divider done held");

endmodule
